// ===== rtl/core/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, codes and helpers for the portfolio return/risk/Sharpe block.
// ----------------------------------------------------------------------------
package prs_pkg;

  // Field and datapath widths
  localparam int DATA_W = 32;   // Q8.24 operand words
  localparam int FRAC_W = 24;   // fraction bits of every product shift
  localparam int RET_W  = 48;   // annual return, signed Q24.24
  localparam int VOL_W  = 47;   // annual volatility, unsigned Q23.24
  localparam int SHP_W  = 32;   // Sharpe ratio, signed Q16.16
  localparam int DVD_W  = 64;   // divider dividend
  localparam int DIV_W  = 48;   // divider divisor and remainder
  localparam int QUO_W  = 32;   // quotient bits produced per division
  localparam int RAD_W  = 64;   // square root radicand
  localparam int ROOT_W = 44;   // square root result
  localparam int CFG_W  = 5;    // asset count register

  // Command codes
  localparam logic [1:0] CMD_MEAN   = 2'd0;
  localparam logic [1:0] CMD_COV    = 2'd1;
  localparam logic [1:0] CMD_WEIGHT = 2'd2;
  localparam logic [1:0] CMD_EVAL   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WSUM0 = 2'd1;
  localparam logic [1:0] ST_VOL0  = 2'd2;

  // Saturation bounds
  localparam logic signed [RET_W-1:0] RET_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RET_W-1:0] RET_MIN = 48'sh8000_0000_0000;
  localparam logic signed [SHP_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SHP_W-1:0] S32_MIN = 32'sh8000_0000;

  // Multiply-accumulate operation tag
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUMW,
    OP_RET,
    OP_COV,
    OP_QF
  } op_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    KIND_OK,
    KIND_WSUM0,
    KIND_VOL0
  } kind_e;

  // Divider operand source
  typedef enum logic {
    DIV_NORM,
    DIV_SHARPE
  } div_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     wr_mean;
    logic     wr_cov;
    logic     wr_weight;
    logic     clr_all;
    logic     clr_t;
    op_e      op;
    logic     div_start;
    div_src_e div_src;
    logic     sqrt_start;
    logic     nw_we;
    logic     out_load;
    kind_e    out_kind;
  } prs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sumw_zero;
    logic var_nonpos;
    logic vol_zero;
    logic div_done;
    logic sqrt_done;
  } prs_stat_t;

  // Apply sign to an unsigned quotient and saturate to signed 32 bits
  function automatic logic signed [SHP_W-1:0] sat_quo(input logic neg, input logic big,
                                                      input logic [QUO_W-1:0] quo);
    logic signed [SHP_W-1:0] res;
    if (neg) begin
      res = (big || quo > 32'h8000_0000) ? S32_MIN : $signed(~quo + 32'd1);
    end else begin
      res = (big || quo > 32'h7FFF_FFFF) ? S32_MAX : $signed(quo);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/prs_if.sv =====
// ----------------------------------------------------------------------------
// prs_in_if / prs_res_if
// Valid/ready channels for commands in and evaluation results out.
// ----------------------------------------------------------------------------
interface prs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [31:0] value;

  modport source (output valid, cmd, row_index, col_index, value, input ready);
  modport sink   (input valid, cmd, row_index, col_index, value, output ready);
endinterface

interface prs_res_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] annual_return;
  logic [46:0]        annual_volatility;
  logic signed [31:0] sharpe_ratio;
  logic [1:0]         status;

  modport source (output valid, annual_return, annual_volatility, sharpe_ratio, status,
                  input ready);
  modport sink   (input valid, annual_return, annual_volatility, sharpe_ratio, status,
                  output ready);
endinterface

// ===== rtl/core/prs_div.sv =====
// ----------------------------------------------------------------------------
// prs_div
// Restoring divider, one quotient bit per cycle, 32 quotient bits. Flags a
// quotient of 2^32 or more so the caller can saturate.
// ----------------------------------------------------------------------------
module prs_div import prs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             big_o,
  output logic             done_o
);

  localparam int STEP_W = $clog2(QUO_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  rem_q, dvs_q;
  logic [QUO_W-1:0]  lo_q;
  logic              big_q;

  logic [DIV_W:0]    sh, diff;
  logic              ge;

  // One restoring step
  always_comb begin
    sh   = {rem_q, lo_q[QUO_W-1]};
    diff = sh - {1'b0, dvs_q};
    ge   = sh >= {1'b0, dvs_q};
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_W'(dividend_i[DVD_W-1:QUO_W]);
      lo_q  <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
      big_q <= DIV_W'(dividend_i[DVD_W-1:QUO_W]) >= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      lo_q  <= {lo_q[QUO_W-2:0], ge};
    end
  end

  assign quo_o  = lo_q;
  assign big_o  = big_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/prs_sqrt.sv =====
// ----------------------------------------------------------------------------
// prs_sqrt
// Digit-by-digit square root, one result bit per cycle: floor(sqrt(v * 2^24)).
// ----------------------------------------------------------------------------
module prs_sqrt import prs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o,
  output logic              done_o
);

  localparam int STEP_W = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 4;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  // Bring down the next bit pair and try the next root bit
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Radicand, remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/prs_dpath.sv =====
// ----------------------------------------------------------------------------
// prs_dpath
// Stores, multiply-accumulate pipeline, divider, square root and the result
// register of the portfolio evaluator.
// ----------------------------------------------------------------------------
module prs_dpath import prs_pkg::*; #(
  parameter  int MAX_ASSETS = 16,
  localparam int IDX_W      = $clog2(MAX_ASSETS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  prs_cmd_t                cmd_i,
  input  logic [IDX_W-1:0]        rd_i_i,
  input  logic [IDX_W-1:0]        rd_j_i,
  input  logic [3:0]              in_row_i,
  input  logic [3:0]              in_col_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  output prs_stat_t               stat_o,
  output logic signed [RET_W-1:0] annual_return_o,
  output logic [VOL_W-1:0]        annual_volatility_o,
  output logic signed [SHP_W-1:0] sharpe_ratio_o,
  output logic [1:0]              status_o
);

  localparam int COV_D  = MAX_ASSETS * MAX_ASSETS;
  localparam int COV_AW = $clog2(COV_D);
  localparam int TERM_W = 2 * DATA_W - FRAC_W;
  localparam int SUM_W  = DATA_W + IDX_W;
  localparam int ACC_W  = TERM_W + IDX_W + 1;
  localparam int PW     = ACC_W + 8;

  // Stores
  logic signed [DATA_W-1:0] mean_mem [MAX_ASSETS];
  logic signed [DATA_W-1:0] wgt_mem  [MAX_ASSETS];
  logic signed [DATA_W-1:0] nw_mem   [MAX_ASSETS];
  logic signed [DATA_W-1:0] cov_mem  [COV_D];

  logic signed [DATA_W-1:0] mean_q, weight_q, nwa_q, nwb_q, cov_q;
  logic                     row_ok, col_ok;
  logic [IDX_W-1:0]         wr_addr;
  logic [COV_AW-1:0]        cov_wa, cov_ra;
  logic signed [DATA_W-1:0] nw_wdata;

  // MAC pipeline
  op_e                      tag1_q, tag2_q;
  logic signed [DATA_W-1:0] mul_a, mul_b, t_clamp;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sumw_q;
  logic signed [ACC_W-1:0]  acc_r_q, acc_t_q, acc_q_q;

  // Derived values
  logic signed [PW-1:0]     r252, var_q;
  logic signed [RET_W-1:0]  ann_ret_d, ann_ret_q;
  logic [DATA_W-1:0]        w_mag;
  logic [SUM_W-1:0]         s_mag;
  logic [RET_W-1:0]         ret_mag;
  logic                     ret_pos;
  logic signed [SHP_W-1:0]  shp_sat;

  // Divider and square root
  logic [DVD_W-1:0]         div_dvd;
  logic [DIV_W-1:0]         div_dvs;
  logic [QUO_W-1:0]         div_quo;
  logic                     div_big, div_done, div_neg_q;
  logic [ROOT_W-1:0]        root;
  logic                     sqrt_done;

  // Load addressing
  always_comb begin
    row_ok  = 32'(in_row_i) < MAX_ASSETS;
    col_ok  = 32'(in_col_i) < MAX_ASSETS;
    wr_addr = IDX_W'(in_row_i);
    cov_wa  = COV_AW'(in_row_i) * COV_AW'(MAX_ASSETS) + COV_AW'(in_col_i);
    cov_ra  = COV_AW'(rd_i_i) * COV_AW'(MAX_ASSETS) + COV_AW'(rd_j_i);
  end

  // Per-asset stores, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mean && row_ok) begin
      mean_mem[wr_addr] <= in_value_i;
    end
    if (cmd_i.wr_weight && row_ok) begin
      wgt_mem[wr_addr] <= in_value_i;
    end
    mean_q   <= mean_mem[rd_i_i];
    weight_q <= wgt_mem[rd_i_i];
  end

  // Normalized weights, two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.nw_we) begin
      nw_mem[rd_i_i] <= nw_wdata;
    end
    nwa_q <= nw_mem[rd_i_i];
    nwb_q <= nw_mem[rd_j_i];
  end

  // Covariance matrix, row-major
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cov && row_ok && col_ok) begin
      cov_mem[cov_wa] <= in_value_i;
    end
    cov_q <= cov_mem[cov_ra];
  end

  // Operation tags follow the data through read and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= OP_NONE;
      tag2_q <= OP_NONE;
    end else begin
      tag1_q <= cmd_i.op;
      tag2_q <= tag1_q;
    end
  end

  // Column sum clamped to Q8.24
  always_comb begin
    if (acc_t_q > ACC_W'(S32_MAX)) begin
      t_clamp = S32_MAX;
    end else if (acc_t_q < ACC_W'(S32_MIN)) begin
      t_clamp = S32_MIN;
    end else begin
      t_clamp = acc_t_q[DATA_W-1:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (tag1_q)
      OP_SUMW: begin
        mul_a = weight_q;
        mul_b = 32'sh0100_0000;
      end
      OP_RET: begin
        mul_a = mean_q;
        mul_b = nwa_q;
      end
      OP_COV: begin
        mul_a = nwa_q;
        mul_b = cov_q;
      end
      OP_QF: begin
        mul_a = t_clamp;
        mul_b = nwb_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Floor shift of the product is its upper bits
  assign term = prod_q[2*DATA_W-1:FRAC_W];

  // Accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_all) begin
      sumw_q  <= '0;
      acc_r_q <= '0;
      acc_t_q <= '0;
      acc_q_q <= '0;
    end else begin
      unique case (tag2_q)
        OP_SUMW: sumw_q  <= sumw_q + SUM_W'(term);
        OP_RET:  acc_r_q <= acc_r_q + ACC_W'(term);
        OP_COV:  acc_t_q <= acc_t_q + ACC_W'(term);
        OP_QF:   acc_q_q <= acc_q_q + ACC_W'(term);
        default: ;
      endcase
      if (cmd_i.clr_t) begin
        acc_t_q <= '0;
      end
    end
  end

  // Annualize: x * 252 = (x << 8) - (x << 2)
  always_comb begin
    r252 = (PW'(acc_r_q) <<< 8) - (PW'(acc_r_q) <<< 2);
    if (r252 > PW'(RET_MAX)) begin
      ann_ret_d = RET_MAX;
    end else if (r252 < PW'(RET_MIN)) begin
      ann_ret_d = RET_MIN;
    end else begin
      ann_ret_d = r252[RET_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ann_ret_q <= ann_ret_d;
    var_q     <= (PW'(acc_q_q) <<< 8) - (PW'(acc_q_q) <<< 2);
  end

  // Divider operands
  always_comb begin
    w_mag   = weight_q[DATA_W-1] ? (~weight_q + 32'd1) : weight_q;
    s_mag   = sumw_q[SUM_W-1] ? (~sumw_q + SUM_W'(1)) : sumw_q;
    ret_mag = ann_ret_q[RET_W-1] ? (~ann_ret_q + RET_W'(1)) : ann_ret_q;
    ret_pos = !ann_ret_q[RET_W-1] && (ann_ret_q != '0);
    if (cmd_i.div_src == DIV_NORM) begin
      div_dvd = {8'b0, w_mag, 24'b0};
      div_dvs = DIV_W'(s_mag);
    end else begin
      div_dvd = {ret_mag, 16'b0};
      div_dvs = DIV_W'(root);
    end
  end

  // Sign of the running division
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_neg_q <= (cmd_i.div_src == DIV_NORM) ? (weight_q[DATA_W-1] ^ sumw_q[SUM_W-1])
                                               : ann_ret_q[RET_W-1];
    end
  end

  assign nw_wdata = sat_quo(div_neg_q, div_big, div_quo);

  prs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quo_o      (div_quo),
    .big_o      (div_big),
    .done_o     (div_done)
  );

  prs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (RAD_W'($unsigned(var_q))),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // Status to the controller
  always_comb begin
    stat_o.sumw_zero  = sumw_q == '0;
    stat_o.var_nonpos = var_q[PW-1] || (var_q == '0);
    stat_o.vol_zero   = root == '0;
    stat_o.div_done   = div_done;
    stat_o.sqrt_done  = sqrt_done;
  end

  // Saturated ratio when the volatility is zero
  assign shp_sat = ret_pos ? S32_MAX : (ann_ret_q[RET_W-1] ? S32_MIN : '0);

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_kind)
        KIND_WSUM0: begin
          annual_return_o     <= '0;
          annual_volatility_o <= '0;
          sharpe_ratio_o      <= '0;
          status_o            <= ST_WSUM0;
        end
        KIND_VOL0: begin
          annual_return_o     <= ann_ret_q;
          annual_volatility_o <= '0;
          sharpe_ratio_o      <= shp_sat;
          status_o            <= ST_VOL0;
        end
        default: begin
          annual_return_o     <= ann_ret_q;
          annual_volatility_o <= VOL_W'(root);
          sharpe_ratio_o      <= nw_wdata;
          status_o            <= ST_OK;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prs_ctrl
// Command sequencer: loads, weight sum, normalization, return, quadratic
// form, square root, Sharpe division and result hand-off.
// ----------------------------------------------------------------------------
module prs_ctrl import prs_pkg::*; #(
  parameter  int MAX_ASSETS = 16,
  localparam int IDX_W      = $clog2(MAX_ASSETS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  prs_stat_t        stat_i,
  output prs_cmd_t         cmd_o,
  output logic [IDX_W-1:0] rd_i_o,
  output logic [IDX_W-1:0] rd_j_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SUM, S_SUM_WAIT, S_NRM_RD, S_NRM_GO, S_NRM_WAIT,
    S_RET, S_RET_WAIT, S_COV, S_COV_WAIT, S_QF, S_QF_WAIT,
    S_ROOT, S_ROOT_WAIT, S_SHP, S_SHP_WAIT, S_FIN
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] i_q, j_q, nm1;
  logic [1:0]       wait_q;
  kind_e            kind_q;
  logic             out_valid_q;
  logic [CFG_W-1:0] asset_count_q;
  logic             accept, i_last;

  // Asset count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asset_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      asset_count_q <= cfg_wdata_i;
    end
  end

  // Last asset index, count clamped to 1..MAX_ASSETS
  always_comb begin
    if (asset_count_q == '0) begin
      nm1 = '0;
    end else if (32'(asset_count_q) > MAX_ASSETS) begin
      nm1 = IDX_W'(MAX_ASSETS - 1);
    end else begin
      nm1 = IDX_W'(asset_count_q - CFG_W'(1));
    end
  end

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign i_last = i_q == nm1;

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_NONE;
    cmd_o.div_src    = (state_q == S_SHP) ? DIV_SHARPE : DIV_NORM;
    cmd_o.out_kind   = kind_q;
    cmd_o.wr_mean    = accept && (in_cmd_i == CMD_MEAN);
    cmd_o.wr_cov     = accept && (in_cmd_i == CMD_COV);
    cmd_o.wr_weight  = accept && (in_cmd_i == CMD_WEIGHT);
    cmd_o.clr_all    = accept && (in_cmd_i == CMD_EVAL);
    cmd_o.clr_t      = (state_q == S_QF_WAIT) && (wait_q == '0);
    cmd_o.div_start  = (state_q == S_NRM_GO) || (state_q == S_SHP);
    cmd_o.sqrt_start = (state_q == S_ROOT) && !stat_i.var_nonpos;
    cmd_o.nw_we      = (state_q == S_NRM_WAIT) && stat_i.div_done;
    cmd_o.out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
    unique case (state_q)
      S_SUM:   cmd_o.op = OP_SUMW;
      S_RET:   cmd_o.op = OP_RET;
      S_COV:   cmd_o.op = OP_COV;
      S_QF:    cmd_o.op = OP_QF;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // State machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      wait_q      <= '0;
      kind_q      <= KIND_OK;
      out_valid_q <= 1'b0;
    end else begin
      // Output register occupancy
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_cmd_i == CMD_EVAL)) begin
            i_q     <= '0;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (i_last) begin
            wait_q  <= 2'd2;
            state_q <= S_SUM_WAIT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_SUM_WAIT: begin
          if (wait_q != '0) begin
            wait_q <= wait_q - 1'b1;
          end else if (stat_i.sumw_zero) begin
            kind_q  <= KIND_WSUM0;
            state_q <= S_FIN;
          end else begin
            i_q     <= '0;
            state_q <= S_NRM_RD;
          end
        end
        S_NRM_RD: state_q <= S_NRM_GO;
        S_NRM_GO: state_q <= S_NRM_WAIT;
        S_NRM_WAIT: begin
          if (stat_i.div_done) begin
            if (i_last) begin
              i_q     <= '0;
              state_q <= S_RET;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_NRM_RD;
            end
          end
        end
        S_RET: begin
          if (i_last) begin
            wait_q  <= 2'd2;
            state_q <= S_RET_WAIT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_RET_WAIT: begin
          if (wait_q != '0) begin
            wait_q <= wait_q - 1'b1;
          end else begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_COV;
          end
        end
        S_COV: begin
          if (i_last) begin
            wait_q  <= 2'd2;
            state_q <= S_COV_WAIT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_COV_WAIT: begin
          if (wait_q != '0) begin
            wait_q <= wait_q - 1'b1;
          end else begin
            state_q <= S_QF;
          end
        end
        S_QF: begin
          wait_q  <= 2'd2;
          state_q <= S_QF_WAIT;
        end
        S_QF_WAIT: begin
          if (wait_q != '0) begin
            wait_q <= wait_q - 1'b1;
          end else if (j_q == nm1) begin
            state_q <= S_ROOT;
          end else begin
            j_q     <= j_q + 1'b1;
            i_q     <= '0;
            state_q <= S_COV;
          end
        end
        S_ROOT: begin
          if (stat_i.var_nonpos) begin
            kind_q  <= KIND_VOL0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_ROOT_WAIT;
          end
        end
        S_ROOT_WAIT: begin
          if (stat_i.sqrt_done) begin
            if (stat_i.vol_zero) begin
              kind_q  <= KIND_VOL0;
              state_q <= S_FIN;
            end else begin
              state_q <= S_SHP;
            end
          end
        end
        S_SHP: state_q <= S_SHP_WAIT;
        S_SHP_WAIT: begin
          if (stat_i.div_done) begin
            kind_q  <= KIND_OK;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign rd_i_o      = i_q;
  assign rd_j_o      = j_q;

  // Checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken transaction");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_cmd_i == CMD_EVAL)) |=> !in_ready_o)
    else $error("evaluate did not leave idle");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("result valid without a load");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> ((state_q == S_NRM_WAIT) || (state_q == S_SHP_WAIT)))
    else $error("divider finished outside a wait state");

endmodule

// ===== rtl/core/portfolio_return_risk_sharpe_top.sv =====
// ----------------------------------------------------------------------------
// portfolio_return_risk_sharpe_top
// Mean-variance portfolio evaluator: annual return, volatility and Sharpe.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries commands: load mean (row), load covariance (row, col),
//         load raw weight (row), or evaluate. A transaction is taken when
//         valid and ready are high at a clock edge.
//   res_o carries one result per evaluate: return, volatility, Sharpe ratio
//         and status. Loads produce no result.
//   cfg_we_i/cfg_wdata_i write the asset count n (clamped to 1..MAX_ASSETS).
// Timing:
//   Loads may stream back to back. An evaluate's run time is set by the
//   single multiplier walking the covariance matrix, the bit-serial divider
//   (once per weight and once for the ratio) and the bit-serial square
//   root. Commands are refused while an evaluate runs.
// Reset clears control state and sets n to 1; stores hold garbage until
// loaded. A stalled receiver holds the result in the output register; the
// next command is still taken, and the next result waits for the register.
// ----------------------------------------------------------------------------
module portfolio_return_risk_sharpe_top import prs_pkg::*; #(
  parameter int MAX_ASSETS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  prs_in_if.sink           in_i,
  prs_res_if.source        res_o
);

  localparam int IDX_W = $clog2(MAX_ASSETS);

  prs_cmd_t         cmd;
  prs_stat_t        stat;
  logic [IDX_W-1:0] rd_i, rd_j;

  prs_ctrl #(.MAX_ASSETS(MAX_ASSETS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_i_o      (rd_i),
    .rd_j_o      (rd_j)
  );

  prs_dpath #(.MAX_ASSETS(MAX_ASSETS)) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .rd_i_i              (rd_i),
    .rd_j_i              (rd_j),
    .in_row_i            (in_i.row_index),
    .in_col_i            (in_i.col_index),
    .in_value_i          (in_i.value),
    .stat_o              (stat),
    .annual_return_o     (res_o.annual_return),
    .annual_volatility_o (res_o.annual_volatility),
    .sharpe_ratio_o      (res_o.sharpe_ratio),
    .status_o            (res_o.status)
  );

endmodule

// ===== dv/portfolio_return_risk_sharpe_top_tb.sv =====
// ----------------------------------------------------------------------------
// portfolio_return_risk_sharpe_top_tb
// Drives load and evaluate commands into the portfolio evaluator and compares
// every result, field by field, with a hand-written value or a fixed-point
// predictor that tracks the mean, covariance and weight stores and asset count.
// ----------------------------------------------------------------------------
module portfolio_return_risk_sharpe_top_tb import prs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int           NUM_ASSETS  = 16;
  localparam int           SETTLE_CYC  = 1100;     // longest evaluate plus margin
  localparam int           CYCLE_LIMIT = 10000000;
  localparam int           HOLD_CYC    = 3000;
  localparam int           PHASE_ITEMS = 120;
  localparam logic [31:0]  Q_ONE       = 32'h0100_0000;
  localparam logic [46:0]  VOL_MAX     = 47'h7FFF_FFFF_FFFF;

  // Expected contents of one result transaction
  typedef struct packed {
    logic signed [RET_W-1:0] ret;
    logic [VOL_W-1:0]        vol;
    logic signed [SHP_W-1:0] shp;
    logic [1:0]              st;
  } port_res_t;

  // One command, optionally with a hand-written expected result
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] val;
    logic        typed;
    port_res_t   res;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  prs_in_if  in_if ();
  prs_res_if res_if ();

  portfolio_return_risk_sharpe_top #(.MAX_ASSETS(NUM_ASSETS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  // Predictor state
  logic signed [31:0] mean_mem [NUM_ASSETS];
  logic signed [31:0] weight_mem [NUM_ASSETS];
  logic signed [31:0] cov_mem [NUM_ASSETS][NUM_ASSETS];
  logic [CFG_W-1:0]   asset_n;

  port_res_t pending_res_q[$];
  int        errors;
  int        cycles;
  int        hold_cnt;
  bit        hold_req;

  // Clock and watchdog
  initial begin
    clk_i  = 1'b0;
    cycles = 0;
    forever begin
      #2 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("%0t timeout after %0d cycles", $time, cycles);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  function automatic longint sat32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(sqrt(v * 2^24)), digit by digit
  function automatic longint unsigned sqrt_q24(input longint unsigned v);
    longint unsigned rem, root, pair, trial;
    rem  = 0;
    root = 0;
    for (int p = 31; p >= -12; p--) begin
      pair  = (p >= 0) ? ((v >> (2 * p)) & 64'd3) : 64'd0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Return, volatility and Sharpe over the first n assets
  function automatic port_res_t eval_portfolio();
    port_res_t       r;
    longint          nw [NUM_ASSETS];
    longint          sum_w, r_acc, q_acc, ret, variance, t, shp;
    longint unsigned vol, mag, quo;
    int              n;
    bit              neg;
    r     = '0;
    sum_w = 0;
    r_acc = 0;
    q_acc = 0;
    n = (asset_n == 0) ? 1 : ((asset_n > NUM_ASSETS) ? NUM_ASSETS : int'(asset_n));
    for (int i = 0; i < n; i++) sum_w += longint'(weight_mem[i]);
    if (sum_w == 0) begin
      r.st = ST_WSUM0;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      nw[i] = sat32((longint'(weight_mem[i]) <<< FRAC_W) / sum_w);
      r_acc += (longint'(mean_mem[i]) * nw[i]) >>> FRAC_W;
    end
    ret = r_acc * 252;
    if (ret > 64'sh7FFF_FFFF_FFFF) ret = 64'sh7FFF_FFFF_FFFF;
    if (ret < -64'sh8000_0000_0000) ret = -64'sh8000_0000_0000;
    for (int j = 0; j < n; j++) begin
      t = 0;
      for (int i = 0; i < n; i++) t += (nw[i] * longint'(cov_mem[i][j])) >>> FRAC_W;
      t = sat32(t);
      q_acc += (t * nw[j]) >>> FRAC_W;
    end
    variance = q_acc * 252;
    neg = ret < 0;
    vol = (variance > 0) ? sqrt_q24(longint'(variance)) : 64'd0;
    if (vol == 0) begin
      r.st = ST_VOL0;
      shp  = (ret > 0) ? 64'sd2147483647 : (neg ? -64'sd2147483648 : 64'sd0);
    end else begin
      r.st = ST_OK;
      mag  = neg ? longint'(-ret) : longint'(ret);
      quo  = (mag << 16) / vol;
      if (neg) shp = (quo > 64'd2147483648) ? -64'sd2147483648 : -longint'(quo);
      else     shp = (quo > 64'd2147483647) ? 64'sd2147483647 : longint'(quo);
    end
    r.ret = ret[RET_W-1:0];
    r.vol = (vol > VOL_MAX) ? VOL_MAX : vol[VOL_W-1:0];
    r.shp = shp[SHP_W-1:0];
    return r;
  endfunction

  // Update predictor for one accepted command
  function automatic void apply_cmd(input cmd_row_t c);
    case (c.cmd)
      CMD_MEAN:   mean_mem[c.row] = c.val;
      CMD_WEIGHT: weight_mem[c.row] = c.val;
      CMD_COV:    cov_mem[c.row][c.col] = c.val;
      CMD_EVAL: begin
        if (c.typed) pending_res_q.insert(pending_res_q.size(), c.res);
        else pending_res_q.insert(pending_res_q.size(), eval_portfolio());
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_row_t ld(input logic [1:0] cmd, input logic [3:0] row,
                                  input logic [3:0] col, input logic [31:0] val);
    cmd_row_t c;
    c     = '0;
    c.cmd = cmd;
    c.row = row;
    c.col = col;
    c.val = val;
    return c;
  endfunction

  function automatic cmd_row_t ev_typed(input logic signed [RET_W-1:0] ret,
                                        input logic signed [SHP_W-1:0] shp,
                                        input logic [1:0] st);
    cmd_row_t c;
    c       = ld(CMD_EVAL, 4'd0, 4'd0, 32'd0);
    c.typed = 1'b1;
    c.res   = '{ret: ret, vol: '0, shp: shp, st: st};
    return c;
  endfunction

  // Drive one transaction and wait for acceptance
  task automatic send(input cmd_row_t c);
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.cmd       <= c.cmd;
    in_if.row_index <= c.row;
    in_if.col_index <= c.col;
    in_if.value     <= c.val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    apply_cmd(c);
  endtask

  task automatic go_idle(input int n);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Wait until the block is quiet, then write the asset count
  task automatic write_count(input logic [CFG_W-1:0] n);
    go_idle(0);
    wait (pending_res_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    asset_n   = n;
  endtask

  function automatic cmd_row_t gen_cmd();
    logic [3:0] row, col;
    int         pick;
    row  = 4'($urandom_range(0, NUM_ASSETS - 1));
    col  = 4'($urandom_range(0, NUM_ASSETS - 1));
    pick = $urandom_range(0, 99);
    // Mostly well-formed portfolio data, the rest raw noise
    if (pick < 14) return ld(CMD_EVAL, row, col, $urandom);
    if (pick < 30) return ld(CMD_WEIGHT, row, col, $urandom_range(0, 32'h0200_0000));
    if (pick < 46) return ld(CMD_MEAN, row, col, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
    if (pick < 70) begin
      if (row == col) return ld(CMD_COV, row, row, $urandom_range(0, Q_ONE));
      return ld(CMD_COV, row, col, $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
    end
    return ld(2'($urandom_range(0, 3)), row, col, $urandom);
  endfunction

  // Result receiver: stall pattern plus one long hold
  initial begin
    int mode;
    res_if.ready = 1'b0;
    hold_cnt     = 0;
    mode         = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYC;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= $urandom_range(0, 1);
          default: res_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    port_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_res_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result ret=%h vol=%h shp=%h st=%0d", $time,
                 res_if.annual_return, res_if.annual_volatility, res_if.sharpe_ratio,
                 res_if.status);
      end else begin
        want = pending_res_q.pop_front();
        if (res_if.annual_return !== want.ret) begin
          errors++;
          $display("%0t return: expected %h, actual %h", $time, want.ret,
                   res_if.annual_return);
        end
        if (res_if.annual_volatility !== want.vol) begin
          errors++;
          $display("%0t volatility: expected %h, actual %h", $time, want.vol,
                   res_if.annual_volatility);
        end
        if (res_if.sharpe_ratio !== want.shp) begin
          errors++;
          $display("%0t sharpe: expected %h, actual %h", $time, want.shp,
                   res_if.sharpe_ratio);
        end
        if (res_if.status !== want.st) begin
          errors++;
          $display("%0t status: expected %0d, actual %0d", $time, want.st, res_if.status);
        end
      end
    end
  end

  // Main sequence
  initial begin
    cmd_row_t       dir_tbl [];
    logic [CFG_W-1:0] counts [10];
    int             burst;
    errors             = 0;
    hold_req           = 1'b0;
    asset_n            = 5'd1;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_MEAN;
    in_if.row_index    = '0;
    in_if.col_index    = '0;
    in_if.value        = '0;
    counts = '{5'd2, 5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd3, 5'd8, 5'd16, 5'd5};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single asset, zero weight sum, zero variance, extreme words
    dir_tbl = '{
      ld(CMD_WEIGHT, 4'd0, 4'd0, 32'd0), ld(CMD_MEAN, 4'd0, 4'd0, Q_ONE),
      ld(CMD_COV, 4'd0, 4'd0, 32'd0), ev_typed('0, '0, ST_WSUM0),
      ld(CMD_WEIGHT, 4'd0, 4'd0, Q_ONE), ev_typed(48'sh0000_FC00_0000, S32_MAX, ST_VOL0),
      ld(CMD_MEAN, 4'd0, 4'd0, -Q_ONE), ev_typed(-48'sh0000_FC00_0000, S32_MIN, ST_VOL0),
      ld(CMD_MEAN, 4'd0, 4'd0, 32'd0), ev_typed('0, '0, ST_VOL0),
      ld(CMD_MEAN, 4'd0, 4'd0, 32'h7FFF_FFFF), ld(CMD_COV, 4'd0, 4'd0, 32'h7FFF_FFFF),
      ld(CMD_EVAL, 4'd0, 4'd0, 32'd0),
      ld(CMD_MEAN, 4'd0, 4'd0, 32'h8000_0000), ld(CMD_COV, 4'd0, 4'd0, Q_ONE),
      ld(CMD_WEIGHT, 4'd0, 4'd0, 32'h7FFF_FFFF), ld(CMD_EVAL, 4'd15, 4'd15, 32'hFFFF_FFFF),
      ld(CMD_WEIGHT, 4'd0, 4'd0, 32'h8000_0000), ld(CMD_EVAL, 4'd0, 4'd0, 32'd0),
      ld(CMD_COV, 4'd0, 4'd0, 32'h8000_0000), ld(CMD_EVAL, 4'd0, 4'd0, 32'd0),
      ld(CMD_MEAN, 4'd15, 4'd0, 32'h7FFF_FFFF), ld(CMD_WEIGHT, 4'd15, 4'd0, 32'h8000_0000),
      ld(CMD_COV, 4'd15, 4'd15, 32'hFFFF_FFFF)
    };
    foreach (dir_tbl[k]) send(dir_tbl[k]);

    // Fill every store entry so any asset count reads written data
    for (int i = 0; i < NUM_ASSETS; i++) begin
      send(ld(CMD_MEAN, 4'(i), 4'd0, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000));
      send(ld(CMD_WEIGHT, 4'(i), 4'd0, $urandom_range(1, 32'h0200_0000)));
      for (int j = 0; j < NUM_ASSETS; j++)
        send(ld(CMD_COV, 4'(i), 4'(j), (i == j) ? $urandom_range(1, Q_ONE) :
                $urandom_range(0, 32'h0020_0000) - 32'h0010_0000));
    end

    // Random phases, one asset count each
    foreach (counts[p]) begin
      write_count(counts[p]);
      burst = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 20) hold_req = 1'b1;
        if (p == 6 && k == 75) begin
          go_idle(0);
          wait (pending_res_q.size() == 0);
        end
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) go_idle($urandom_range(0, 6));
        end
        burst--;
        send(gen_cmd());
      end
    end
    go_idle(0);

    // Drain
    wait (pending_res_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/prs_pkg.sv
rtl/core/prs_if.sv
rtl/core/prs_div.sv
rtl/core/prs_sqrt.sv
rtl/core/prs_dpath.sv
rtl/core/prs_ctrl.sv
rtl/core/portfolio_return_risk_sharpe_top.sv
dv/portfolio_return_risk_sharpe_top_tb.sv
